// ===== rtl/core/tea_pkg.sv =====
`timescale 1ns / 1ps

package tea_pkg;

  // Round constant added to the running sum once per cycle.
  localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_ROUNDS = 3'd4;

  // Direction codes.
  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  // Reset values of the key words and the cycle count.
  localparam logic [31:0] KEY0_RESET   = 32'h46343341;
  localparam logic [31:0] KEY1_RESET   = 32'h31373739;
  localparam logic [31:0] KEY2_RESET   = 32'h30314345;
  localparam logic [31:0] KEY3_RESET   = 32'h35414342;
  localparam logic [6:0]  ROUNDS_RESET = 7'd16;

  // Four key words, indexed by the two key select bits.
  typedef logic [3:0][31:0] key_t;

  // Control that travels down the pipeline with each request.
  typedef struct packed {
    logic valid;
    logic func;
  } ctrl_t;

  // The mixing term of one half-step.
  function automatic logic [31:0] tea_mix(input logic [31:0] w,
                                          input logic [31:0] sum,
                                          input logic [31:0] k);
    return ((w << 4) ^ (w >> 5)) + (w ^ sum) + k;
  endfunction

endpackage

// ===== rtl/core/tea_round.sv =====
`timescale 1ns / 1ps

// One TEA cycle as two register stages, one half-step in each. The running
// sums are fixed per position, so they are elaboration constants here.
module tea_round
  import tea_pkg::*;
#(
  parameter int MAX_ROUNDS = 64,
  parameter int ROUND_IDX  = 0,
  parameter int RW         = $clog2(MAX_ROUNDS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  key_t          key,
  input  ctrl_t         in_ctrl,
  input  logic [RW-1:0] in_rounds,
  input  logic [31:0]   in_y,
  input  logic [31:0]   in_z,
  output ctrl_t         out_ctrl,
  output logic [RW-1:0] out_rounds,
  output logic [31:0]   out_y,
  output logic [31:0]   out_z
);

  // Encryption runs in the first positions, decryption in the last ones.
  localparam logic [31:0] SUM_ENC_A = TEA_DELTA * 32'(ROUND_IDX);
  localparam logic [31:0] SUM_ENC_B = TEA_DELTA * 32'(ROUND_IDX + 1);
  localparam logic [31:0] SUM_DEC_A = TEA_DELTA * 32'(MAX_ROUNDS - ROUND_IDX);
  localparam logic [31:0] SUM_DEC_B = TEA_DELTA * 32'(MAX_ROUNDS - ROUND_IDX - 1);
  localparam logic [RW-1:0] ENC_LIMIT = RW'(ROUND_IDX);
  localparam logic [RW-1:0] DEC_LIMIT = RW'(MAX_ROUNDS - ROUND_IDX);

  ctrl_t         mid_ctrl;
  logic [RW-1:0] mid_rounds;
  logic [31:0]   mid_y;
  logic [31:0]   mid_z;
  logic [31:0]   mid_y_next;
  logic [31:0]   mid_z_next;
  logic [31:0]   out_y_next;
  logic [31:0]   out_z_next;
  logic          act_a;
  logic          act_b;

  // First half-step: y on encrypt, z on decrypt.
  always_comb begin
    mid_y_next = in_y;
    mid_z_next = in_z;
    if (in_ctrl.func == FUNC_DECRYPT) begin
      act_a = (in_rounds >= DEC_LIMIT);
      if (act_a) begin
        mid_z_next = in_z - tea_mix(in_y, SUM_DEC_A, key[SUM_DEC_A[12:11]]);
      end
    end else begin
      act_a = (in_rounds > ENC_LIMIT);
      if (act_a) begin
        mid_y_next = in_y + tea_mix(in_z, SUM_ENC_A, key[SUM_ENC_A[1:0]]);
      end
    end
  end

  // Second half-step: z on encrypt, y on decrypt.
  always_comb begin
    out_y_next = mid_y;
    out_z_next = mid_z;
    if (mid_ctrl.func == FUNC_DECRYPT) begin
      act_b = (mid_rounds >= DEC_LIMIT);
      if (act_b) begin
        out_y_next = mid_y - tea_mix(mid_z, SUM_DEC_B, key[SUM_DEC_B[1:0]]);
      end
    end else begin
      act_b = (mid_rounds > ENC_LIMIT);
      if (act_b) begin
        out_z_next = mid_z + tea_mix(mid_y, SUM_ENC_B, key[SUM_ENC_B[12:11]]);
      end
    end
  end

  // Control registers: valid bits clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_ctrl <= '0;
      out_ctrl <= '0;
    end else begin
      mid_ctrl <= in_ctrl;
      out_ctrl <= mid_ctrl;
    end
  end

  // Data registers advance every cycle.
  always_ff @(posedge clk) begin
    mid_rounds <= in_rounds;
    mid_y      <= mid_y_next;
    mid_z      <= mid_z_next;
    out_rounds <= mid_rounds;
    out_y      <= out_y_next;
    out_z      <= out_z_next;
  end

endmodule

// ===== rtl/core/tea_block_cipher.sv =====
`timescale 1ns / 1ps

// Channel    | Direction | Handshake            | Payload
// -----------+-----------+----------------------+----------------------------------
// request    | in        | start, busy          | func, word_first, word_second
// result     | out       | done (one cycle)     | result_first, result_second
// config     | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// A request is taken in every cycle in which start is high and busy is low.
// Its result passes through the whole unrolled chain of MAX_ROUNDS cycle units,
// with two register stages each, whatever round_count is.
// Reset clears all valid bits; busy is high during reset and the cycle after.
// The pipeline never stalls, since the result side cannot hold results off.
module tea_block_cipher
  import tea_pkg::*;
#(
  parameter int MAX_ROUNDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [31:0] word_first,
  input  logic [31:0] word_second,
  output logic        done,
  output logic [31:0] result_first,
  output logic [31:0] result_second,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int RW    = $clog2(MAX_ROUNDS + 1);
  localparam int CMP_W = 9;

  key_t          key;
  logic [6:0]    round_count;
  logic [RW-1:0] rounds_sat;

  ctrl_t         ctrl_chain   [MAX_ROUNDS + 1];
  logic [RW-1:0] rounds_chain [MAX_ROUNDS + 1];
  logic [31:0]   y_chain      [MAX_ROUNDS + 1];
  logic [31:0]   z_chain      [MAX_ROUNDS + 1];

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0]      <= KEY0_RESET;
      key[1]      <= KEY1_RESET;
      key[2]      <= KEY2_RESET;
      key[3]      <= KEY3_RESET;
      round_count <= ROUNDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY0:   key[0]      <= cfg_data;
        REG_KEY1:   key[1]      <= cfg_data;
        REG_KEY2:   key[2]      <= cfg_data;
        REG_KEY3:   key[3]      <= cfg_data;
        REG_ROUNDS: round_count <= cfg_data[6:0];
        default:    ;
      endcase
    end
  end

  // Busy only while coming out of reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Counts above MAX_ROUNDS saturate to MAX_ROUNDS.
  always_comb begin
    if (CMP_W'(round_count) > CMP_W'(MAX_ROUNDS)) begin
      rounds_sat = RW'(MAX_ROUNDS);
    end else begin
      rounds_sat = RW'(round_count);
    end
  end

  // Pipeline entry.
  assign ctrl_chain[0].valid = start && !busy;
  assign ctrl_chain[0].func  = func;
  assign rounds_chain[0]     = rounds_sat;
  assign y_chain[0]          = word_first;
  assign z_chain[0]          = word_second;

  // One unit per TEA cycle.
  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_round
    tea_round #(
      .MAX_ROUNDS(MAX_ROUNDS),
      .ROUND_IDX (i),
      .RW        (RW)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .in_ctrl   (ctrl_chain[i]),
      .in_rounds (rounds_chain[i]),
      .in_y      (y_chain[i]),
      .in_z      (z_chain[i]),
      .out_ctrl  (ctrl_chain[i+1]),
      .out_rounds(rounds_chain[i+1]),
      .out_y     (y_chain[i+1]),
      .out_z     (z_chain[i+1])
    );
  end

  // The last stage registers drive the result ports.
  assign done          = ctrl_chain[MAX_ROUNDS].valid;
  assign result_first  = y_chain[MAX_ROUNDS];
  assign result_second = z_chain[MAX_ROUNDS];

endmodule

// ===== rtl/core/tea_chk.sv =====
`timescale 1ns / 1ps

// Port-level checks on request and result timing.
module tea_chk #(
  parameter int MAX_ROUNDS = 64
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LAT   = 2 * MAX_ROUNDS;
  localparam int WARM_W = $clog2(LAT + 1);

  logic [WARM_W-1:0] warm;
  logic              accept;

  assign accept = start && !busy;

  // Cycles since reset, saturating at the pipeline latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      warm <= '0;
    end else if (warm != WARM_W'(LAT)) begin
      warm <= warm + WARM_W'(1);
    end
  end

  // Every result comes from a request taken one latency earlier.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching request");

  // Every request taken yields a result one latency later.
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (warm == WARM_W'(LAT)) && $past(accept, LAT) |-> done)
    else $error("request taken but no result delivered");

  // No request is taken right after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low in the cycle after reset");

endmodule

bind tea_block_cipher tea_chk #(.MAX_ROUNDS(MAX_ROUNDS)) u_tea_chk (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

// ===== test/tea_block_cipher_test.sv =====
`timescale 1ns / 1ps

module tea_block_cipher_test;
  import tea_pkg::*;

  localparam int CIPHER_MAX_ROUNDS = 64;
  localparam int LATENCY = 2 * CIPHER_MAX_ROUNDS;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 124;
  localparam logic [2:0] REG_INDEX_TOP = 3'd7;

  typedef struct packed {
    logic        dir;
    logic [31:0] first;
    logic [31:0] second;
  } request_t;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } block_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        func = FUNC_ENCRYPT;
  logic [31:0] word_first = '0;
  logic [31:0] word_second = '0;
  logic        done;
  logic [31:0] result_first;
  logic [31:0] result_second;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Local copy of the cipher configuration, updated on each accepted write.
  logic [3:0][31:0] key_model = {KEY3_RESET, KEY2_RESET, KEY1_RESET, KEY0_RESET};
  logic [6:0]       rounds_model = ROUNDS_RESET;

  request_t   request_q[$];
  block_t     pending_results[$];
  reg_write_t reg_write_q[$];
  request_t   next_request;
  reg_write_t next_write;
  block_t     wanted;

  int  gap_left = 0;
  bit  steady = 1'b0;
  int  stall_cycles = 0;
  int  failures = 0;
  int  n_encrypt = 0;
  int  n_decrypt = 0;
  int  n_results = 0;
  int  n_writes = 0;
  int  n_settings = 0;

  tea_block_cipher #(
    .MAX_ROUNDS(CIPHER_MAX_ROUNDS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .word_first(word_first),
    .word_second(word_second),
    .done(done),
    .result_first(result_first),
    .result_second(result_second),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One Feistel mixing term: shifted word mixed with the sum, plus a key word.
  function automatic logic [31:0] half_step(input logic [31:0] w, input logic [31:0] s,
                                            input logic [31:0] k);
    return ((w << 4) ^ (w >> 5)) + (w ^ s) + k;
  endfunction

  // Expected cipher output for one request under the current configuration.
  function automatic block_t tea_transform(input logic dir, input logic [31:0] y_in,
                                           input logic [31:0] z_in);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    int          cycles;
    y = y_in;
    z = z_in;
    cycles = (rounds_model > CIPHER_MAX_ROUNDS) ? CIPHER_MAX_ROUNDS : int'(rounds_model);
    if (dir == FUNC_ENCRYPT) begin
      s = '0;
      for (int r = 0; r < cycles; r++) begin
        y = y + half_step(z, s, key_model[s[1:0]]);
        s = s + TEA_DELTA;
        z = z + half_step(y, s, key_model[s[12:11]]);
      end
    end else begin
      s = 32'(TEA_DELTA * 32'(cycles));
      for (int r = 0; r < cycles; r++) begin
        z = z - half_step(y, s, key_model[s[12:11]]);
        s = s - TEA_DELTA;
        y = y - half_step(z, s, key_model[s[1:0]]);
      end
    end
    return '{first: y, second: z};
  endfunction

  // Data words are mostly random, with some all-zero, all-one, single-bit and single-zero-bit patterns.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  // Idle cycles after a request: mostly none or short, a few long; none while steady is set.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 99) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic add_request(input logic dir, input logic [31:0] a, input logic [31:0] b);
    request_q.push_back('{dir: dir, first: a, second: b});
  endtask

  task automatic add_write(input logic [2:0] index, input logic [31:0] data);
    reg_write_q.push_back('{index: index, data: data});
  endtask

  // Wait until all writes and requests are through and no result is pending.
  task automatic settle();
    @(negedge clk);
    while (reg_write_q.size() != 0 || cfg_valid || request_q.size() != 0 || start ||
           pending_results.size() != 0)
      @(negedge clk);
  endtask

  // A random register setting, with the round count often at its edges.
  task automatic configure_random();
    logic [31:0] data;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: data = '0;
          1: data = '1;
          default: data = $urandom();
        endcase
        add_write(REG_KEY0 + 3'(k), data);
      end
    end
    data = $urandom();
    case ($urandom_range(0, 9))
      0: data[6:0] = 7'd0;
      1: data[6:0] = 7'd64;
      2: data[6:0] = 7'd1;
      3: data[6:0] = 7'($urandom_range(65, 127));
      default: data[6:0] = 7'($urandom_range(1, 64));
    endcase
    add_write(REG_ROUNDS, data);
    if ($urandom_range(0, 3) == 0)
      add_write(3'($urandom_range(REG_ROUNDS + 1, REG_INDEX_TOP)), $urandom());
    n_settings++;
  endtask

  // Request driver: predicts each accepted request, then loads the next one.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!start || !busy) begin
      if (start) begin
        pending_results.push_back(tea_transform(func, word_first, word_second));
        if (func == FUNC_DECRYPT) n_decrypt++;
        else n_encrypt++;
      end
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() != 0) begin
        next_request = request_q.pop_front();
        start <= 1'b1;
        func <= next_request.dir;
        word_first <= next_request.first;
        word_second <= next_request.second;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Configuration driver: applies each accepted write to the local copy.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_model[cfg_index[1:0]] = cfg_data;
          REG_ROUNDS: rounds_model = cfg_data[6:0];
          default: ;
        endcase
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_write_q.size() != 0) begin
          next_write = reg_write_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_write.index;
          cfg_data <= next_write.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result %h %h with no request outstanding",
                               result_first, result_second));
      end else begin
        wanted = pending_results.pop_front();
        if (result_first !== wanted.first)
          note_failure($sformatf("result_first expected %h got %h",
                                 wanted.first, result_first));
        if (result_second !== wanted.second)
          note_failure($sformatf("result_second expected %h got %h",
                                 wanted.second, result_second));
      end
    end
  end

  // Watchdog: a long stretch with no handshake of any kind ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles.", stall_cycles);
      $display("tea_block_cipher_test: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset key and round count, extreme and patterned blocks both ways.
    n_settings++;
    add_request(FUNC_ENCRYPT, 32'h0, 32'h0);
    add_request(FUNC_DECRYPT, 32'h0, 32'h0);
    add_request(FUNC_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
    add_request(FUNC_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
    add_request(FUNC_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
    add_request(FUNC_DECRYPT, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    settle();

    // Zero round count passes the block through; unused indexes change nothing.
    add_write(REG_ROUNDS, 32'h0);
    for (int idx = REG_ROUNDS + 1; idx <= REG_INDEX_TOP; idx++)
      add_write(3'(idx), $urandom());
    n_settings++;
    settle();
    add_request(FUNC_ENCRYPT, pick_word(), pick_word());
    add_request(FUNC_DECRYPT, pick_word(), pick_word());
    settle();

    // All-ones key with the largest round count, which saturates.
    add_write(REG_KEY0, 32'hffff_ffff);
    add_write(REG_KEY1, 32'hffff_ffff);
    add_write(REG_KEY2, 32'hffff_ffff);
    add_write(REG_KEY3, 32'hffff_ffff);
    add_write(REG_ROUNDS, 32'hffff_ffff);
    n_settings++;
    settle();
    add_request(FUNC_ENCRYPT, pick_word(), pick_word());
    add_request(FUNC_DECRYPT, pick_word(), pick_word());
    settle();

    // Just above the limit.
    add_write(REG_ROUNDS, 32'd65);
    n_settings++;
    settle();
    add_request(FUNC_ENCRYPT, pick_word(), pick_word());
    add_request(FUNC_DECRYPT, pick_word(), pick_word());
    settle();

    // All-zero key with a single cycle.
    add_write(REG_KEY0, 32'h0);
    add_write(REG_KEY1, 32'h0);
    add_write(REG_KEY2, 32'h0);
    add_write(REG_KEY3, 32'h0);
    add_write(REG_ROUNDS, 32'd1);
    n_settings++;
    settle();
    add_request(FUNC_ENCRYPT, 32'hffff_ffff, 32'h0);
    add_request(FUNC_DECRYPT, 32'h0, 32'hffff_ffff);
    settle();

    // Random key at exactly the limit.
    add_write(REG_KEY0, $urandom());
    add_write(REG_KEY1, $urandom());
    add_write(REG_KEY2, $urandom());
    add_write(REG_KEY3, $urandom());
    add_write(REG_ROUNDS, 32'd64);
    n_settings++;
    settle();
    add_request(FUNC_ENCRYPT, pick_word(), pick_word());
    add_request(FUNC_DECRYPT, pick_word(), pick_word());
    settle();

    // Random phases, each under a fresh setting; some run back to back.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure_random();
      settle();
      steady = (p % 4 == 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        add_request(logic'($urandom_range(0, 1)), pick_word(), pick_word());
      settle();
      steady = 1'b0;
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    $display("Checked %0d results for %0d requests (%0d encrypt, %0d decrypt).",
             n_results, n_encrypt + n_decrypt, n_encrypt, n_decrypt);
    $display("%0d register writes over %0d settings, round counts from zero to saturation.",
             n_writes, n_settings);
    if (failures == 0) begin
      $display("tea_block_cipher_test: clean");
    end else begin
      $display("%0d mismatches in total.", failures);
      $display("tea_block_cipher_test: errors");
    end
    $finish;
  end

endmodule

// ===== tea_block_cipher.f =====
rtl/core/tea_pkg.sv
rtl/core/tea_round.sv
rtl/core/tea_block_cipher.sv
rtl/core/tea_chk.sv
test/tea_block_cipher_test.sv
